/* src/acl_flt_pkg.sv */
// Shared constants, codes and handshake structs of the access table with fail lockout.
package acl_flt_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   localparam int FUNC_W      = 2;
   localparam int ADDR_W      = 32;
   localparam int ENTRY_IDX_W = 10;
   localparam int KIND_W      = 3;
   localparam int RANGE_W     = 3;
   localparam int FAILS_W     = 4;
   localparam int TRIES_W     = 4;
   localparam int VERDICT_W   = 2;

   // wide enough for both the input slot index plus one and the table depth
   localparam int CMP_W = (CNT_W > ENTRY_IDX_W) ? CNT_W : ENTRY_IDX_W + 1;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] CSR_IDX_MAX_TRIES = '0;
   localparam logic [TRIES_W-1:0]    MAX_TRIES_RESET   = 4'd5;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_CHECK = 2'd0,
      FUNC_FAIL  = 2'd1,
      FUNC_WRITE = 2'd2,
      FUNC_NOP   = 2'd3
   } func_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_FREE    = 3'd0,
      KIND_BANNED  = 3'd1,
      KIND_GRANTED = 3'd2,
      KIND_DIRECT  = 3'd3,
      KIND_HAMMER  = 3'd4,
      KIND_MARKED  = 3'd5
   } kind_type;

   typedef enum logic [VERDICT_W-1:0] {
      VERDICT_ALLOWED = 2'd0,
      VERDICT_BANNED  = 2'd1,
      VERDICT_DIRECT  = 2'd2
   } verdict_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [ADDR_W-1:0]  addr;
      logic [ADDR_W-1:0]  mask;
      logic [RANGE_W-1:0] rng;
      logic [FAILS_W-1:0] fails;
   } slot_entry_type;

   typedef struct packed {
      logic load;
      logic clear_wr;
      logic scan_rd;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic issue_done;
      logic found;
      logic rd_pending;
   } dp_status_type;

endpackage

/* src/acl_flt_ctrl.sv */
// Sequencer: clearing pass, table scan and finishing step of each item.
module acl_flt_ctrl
   import acl_flt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [FUNC_W-1:0]   req_func,
   input  dp_status_type       status,
   output dp_cmd_type          cmd,
   output logic                busy
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type state_ff;
   logic      busy_ff;
   logic      scan_end;

   assign busy     = busy_ff;
   assign scan_end = (status.issue_done | status.found) & ~status.rd_pending;

   always_comb begin
      cmd          = '0;
      cmd.load     = (state_ff == ST_IDLE) & start;
      cmd.clear_wr = (state_ff == ST_CLEAR);
      cmd.scan_rd  = (state_ff == ST_SCAN) & ~status.issue_done & ~status.found;
      cmd.finish   = (state_ff == ST_FINISH);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         busy_ff  <= 1'b1;
      end else begin
         unique case (state_ff)
            ST_CLEAR: begin
               if (status.clear_last) begin
                  state_ff <= ST_IDLE;
                  busy_ff  <= 1'b0;
               end
            end
            ST_IDLE: begin
               if (start) begin
                  busy_ff <= 1'b1;
                  case (req_func) inside
                     FUNC_CHECK, FUNC_FAIL: state_ff <= ST_SCAN;
                     default:               state_ff <= ST_FINISH;
                  endcase
               end
            end
            ST_SCAN: begin
               if (scan_end) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               state_ff <= ST_IDLE;
               busy_ff  <= 1'b0;
            end
            default: begin
               state_ff <= ST_IDLE;
               busy_ff  <= 1'b0;
            end
         endcase
      end
   end

endmodule

/* src/acl_flt_dpath.sv */
// Slot memory, scan evaluation, entry update and result registers.
module acl_flt_dpath
   import acl_flt_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  dp_cmd_type              cmd,
   output dp_status_type           status,
   input  logic [TRIES_W-1:0]      max_tries,
   input  logic [FUNC_W-1:0]       req_func,
   input  logic [ADDR_W-1:0]       req_ip_address,
   input  logic [ENTRY_IDX_W-1:0]  req_entry_index,
   input  logic [KIND_W-1:0]       req_entry_type,
   input  logic [ADDR_W-1:0]       req_entry_mask,
   input  logic [RANGE_W-1:0]      req_entry_range,
   output logic                    rsp_strobe,
   output logic [VERDICT_W-1:0]    rsp_verdict,
   output logic [TRIES_W-1:0]      rsp_tries_left,
   output logic                    rsp_table_full
);

   slot_entry_type mem [TABLE_DEPTH];

   // latched item
   logic [FUNC_W-1:0]      op_ff;
   logic [ADDR_W-1:0]      ip_ff;
   logic [ENTRY_IDX_W-1:0] idx_ff;
   logic [KIND_W-1:0]      kind_ff;
   logic [ADDR_W-1:0]      mask_ff;
   logic [RANGE_W-1:0]     rng_ff;

   logic [CNT_W-1:0]       used_count_ff, used_count_in;
   logic [CNT_W-1:0]       scan_idx_ff;

   slot_entry_type         rd_data_ff;
   logic [IDX_W-1:0]       rd_idx_ff;
   logic                   rd_vld_ff;

   logic [RANGE_W-1:0]     best_rng_ff;
   logic [KIND_W-1:0]      best_kind_ff;
   logic                   found_ff;
   slot_entry_type         hit_ff;
   logic [IDX_W-1:0]       hit_idx_ff;
   logic                   free_found_ff;
   logic [IDX_W-1:0]       free_idx_ff;

   logic                   rsp_strobe_ff;
   logic [VERDICT_W-1:0]   rsp_verdict_ff, rsp_verdict_in;
   logic [TRIES_W-1:0]     rsp_tries_ff, rsp_tries_in;
   logic                   rsp_full_ff, rsp_full_in;

   logic                   mem_we;
   logic [IDX_W-1:0]       mem_waddr;
   slot_entry_type         mem_wdata;

   logic                   match_chk;
   logic                   match_fail;
   logic [FAILS_W-1:0]     hit_fails_inc;
   logic                   hit_hammer;
   logic                   new_hammer;
   logic                   room;
   logic                   wr_in_range;
   logic [TRIES_W-1:0]     tries_first;

   function automatic logic [RANGE_W-1:0] zero_octets(input logic [ADDR_W-1:0] a);
      logic [RANGE_W-1:0] n;
      n = '0;
      for (int k = 0; k < 4; k++) begin
         if (a[8*k +: 8] == 8'h00) begin
            n = n + RANGE_W'(1);
         end
      end
      return n;
   endfunction

   assign match_chk  = (rd_data_ff.kind != KIND_FREE) &&
                       ((ip_ff & rd_data_ff.mask) == rd_data_ff.addr);
   assign match_fail = (rd_data_ff.kind != KIND_FREE) && (rd_data_ff.kind != KIND_GRANTED) &&
                       (rd_data_ff.kind != KIND_DIRECT) && (rd_data_ff.addr == ip_ff);

   assign hit_fails_inc = (hit_ff.fails == '1) ? hit_ff.fails : hit_ff.fails + FAILS_W'(1);
   assign hit_hammer    = (hit_fails_inc >= max_tries);
   assign new_hammer    = (max_tries <= TRIES_W'(1));
   assign tries_first   = new_hammer ? '0 : max_tries - TRIES_W'(1);
   assign room          = (used_count_ff != CNT_W'(TABLE_DEPTH));
   assign wr_in_range   = (CMP_W'(idx_ff) < CMP_W'(TABLE_DEPTH));

   assign status.clear_last = (scan_idx_ff == CNT_W'(TABLE_DEPTH - 1));
   assign status.issue_done = (scan_idx_ff >= used_count_ff);
   assign status.found      = found_ff;
   assign status.rd_pending = rd_vld_ff;

   // clearing-pass slot write, or finishing step: result and the one table write it may cause
   always_comb begin
      mem_we         = 1'b0;
      mem_waddr      = scan_idx_ff[IDX_W-1:0];
      mem_wdata      = '0;
      mem_wdata.kind = KIND_FREE;
      used_count_in  = used_count_ff;
      rsp_verdict_in = VERDICT_ALLOWED;
      rsp_tries_in   = '0;
      rsp_full_in    = 1'b0;
      if (cmd.clear_wr) begin
         mem_we = 1'b1;
      end else if (cmd.finish) begin
         case (op_ff)
            FUNC_CHECK: begin
               case (best_kind_ff) inside
                  KIND_BANNED, KIND_HAMMER: rsp_verdict_in = VERDICT_BANNED;
                  KIND_DIRECT:              rsp_verdict_in = VERDICT_DIRECT;
                  default:                  rsp_verdict_in = VERDICT_ALLOWED;
               endcase
            end
            FUNC_FAIL: begin
               if (found_ff) begin
                  mem_we          = 1'b1;
                  mem_waddr       = hit_idx_ff;
                  mem_wdata       = hit_ff;
                  mem_wdata.fails = hit_fails_inc;
                  if (hit_hammer) begin
                     mem_wdata.kind = KIND_HAMMER;
                  end else begin
                     rsp_tries_in = max_tries - hit_fails_inc;
                  end
               end else if (free_found_ff || room) begin
                  mem_we          = 1'b1;
                  mem_waddr       = free_found_ff ? free_idx_ff : used_count_ff[IDX_W-1:0];
                  mem_wdata.kind  = new_hammer ? KIND_HAMMER : KIND_MARKED;
                  mem_wdata.addr  = ip_ff;
                  mem_wdata.mask  = '1;
                  mem_wdata.rng   = zero_octets(ip_ff);
                  mem_wdata.fails = FAILS_W'(1);
                  rsp_tries_in    = tries_first;
                  if (!free_found_ff) begin
                     used_count_in = used_count_ff + CNT_W'(1);
                  end
               end else begin
                  rsp_full_in  = 1'b1;
                  rsp_tries_in = tries_first;
               end
            end
            FUNC_WRITE: begin
               if (wr_in_range) begin
                  mem_we          = 1'b1;
                  mem_waddr       = IDX_W'(idx_ff);
                  mem_wdata.kind  = kind_ff;
                  mem_wdata.addr  = ip_ff;
                  mem_wdata.mask  = mask_ff;
                  mem_wdata.rng   = rng_ff;
                  mem_wdata.fails = '0;
                  if (CMP_W'(used_count_ff) < CMP_W'(idx_ff) + CMP_W'(1)) begin
                     used_count_in = CNT_W'(CMP_W'(idx_ff) + CMP_W'(1));
                  end
               end
            end
            default: begin
               rsp_full_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.scan_rd) begin
         rd_data_ff <= mem[scan_idx_ff[IDX_W-1:0]];
         rd_idx_ff  <= scan_idx_ff[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_func;
         ip_ff   <= req_ip_address;
         idx_ff  <= req_entry_index;
         kind_ff <= req_entry_type;
         mask_ff <= req_entry_mask;
         rng_ff  <= req_entry_range;
      end
      if (rd_vld_ff && (op_ff == FUNC_FAIL) && !found_ff && match_fail) begin
         hit_ff     <= rd_data_ff;
         hit_idx_ff <= rd_idx_ff;
      end
      if (rd_vld_ff && (op_ff == FUNC_FAIL) && !found_ff && !free_found_ff &&
          (rd_data_ff.kind == KIND_FREE)) begin
         free_idx_ff <= rd_idx_ff;
      end
      if (cmd.finish) begin
         rsp_verdict_ff <= rsp_verdict_in;
         rsp_tries_ff   <= rsp_tries_in;
         rsp_full_ff    <= rsp_full_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_count_ff <= '0;
         scan_idx_ff   <= '0;
         rd_vld_ff     <= 1'b0;
         best_rng_ff   <= RANGE_W'(5);
         best_kind_ff  <= KIND_FREE;
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         used_count_ff <= used_count_in;
         rd_vld_ff     <= cmd.scan_rd;
         rsp_strobe_ff <= cmd.finish;
         if (cmd.load) begin
            scan_idx_ff   <= '0;
            best_rng_ff   <= RANGE_W'(5);
            best_kind_ff  <= KIND_FREE;
            found_ff      <= 1'b0;
            free_found_ff <= 1'b0;
         end else begin
            if (cmd.scan_rd || cmd.clear_wr) begin
               scan_idx_ff <= scan_idx_ff + CNT_W'(1);
            end
            // keep the first matching entry with the smallest range below 5
            if (rd_vld_ff && (op_ff == FUNC_CHECK) && match_chk &&
                (rd_data_ff.rng < best_rng_ff)) begin
               best_rng_ff  <= rd_data_ff.rng;
               best_kind_ff <= rd_data_ff.kind;
            end
            if (rd_vld_ff && (op_ff == FUNC_FAIL) && !found_ff) begin
               if (match_fail) begin
                  found_ff <= 1'b1;
               end else if (rd_data_ff.kind == KIND_FREE) begin
                  free_found_ff <= 1'b1;
               end
            end
         end
      end
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_verdict    = rsp_verdict_ff;
   assign rsp_tries_left = rsp_tries_ff;
   assign rsp_table_full = rsp_full_ff;

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |=> !rsp_strobe_ff)
      else $error("result strobe held for more than one cycle");

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("used count beyond table depth");

   a_full_only_at_depth: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_full_ff) |-> (used_count_ff == CNT_W'(TABLE_DEPTH)))
      else $error("table full reported with room left");

   a_verdict_check_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && (op_ff != FUNC_CHECK)) |-> (rsp_verdict_ff == VERDICT_ALLOWED))
      else $error("verdict set by an item that is not a check");

   a_scan_read_in_use: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_rd |-> (scan_idx_ff < used_count_ff))
      else $error("scan read beyond the used part of the table");

endmodule

/* src/ip_acl_fail_lockout_table.sv */
// Top level of the IPv4 access table with failed-authentication lockout.
//
// Items enter on the req_ ports when start is high and busy is low. func selects
// a check (verdict for an address), a bad authentication (count a failure, maybe
// ban), a write of one table slot or a no-op. Every item gives exactly one result, shown
// on the rsp_ ports for one cycle while rsp_strobe is high; the receiver cannot
// stall it, and the result register lets the next item be accepted in that cycle.
// A check or a bad authentication scans the used slots through the slot memory's
// single read port, one slot per cycle: a check reads every used slot, while a bad
// authentication stops early at its matching slot. A write or a no-op skips the
// scan and goes straight from accept to its finishing step. After reset, busy
// stays high while a clearing pass marks every slot free; the max_tries register
// at byte address 0 of the APB port (reset 5) can be written during that pass and
// whenever busy is low.
module ip_acl_fail_lockout_table
   import acl_flt_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [FUNC_W-1:0]       req_func,
   input  logic [ADDR_W-1:0]       req_ip_address,
   input  logic [ENTRY_IDX_W-1:0]  req_entry_index,
   input  logic [KIND_W-1:0]       req_entry_type,
   input  logic [ADDR_W-1:0]       req_entry_mask,
   input  logic [RANGE_W-1:0]      req_entry_range,
   output logic                    rsp_strobe,
   output logic [VERDICT_W-1:0]    rsp_verdict,
   output logic [TRIES_W-1:0]      rsp_tries_left,
   output logic                    rsp_table_full,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [CSR_ADDR_W-1:0]   paddr,
   input  logic [CSR_DATA_W-1:0]   pwdata,
   output logic [CSR_DATA_W-1:0]   prdata,
   output logic                    pready
);

   logic [TRIES_W-1:0] max_tries_ff;
   dp_cmd_type         cmd;
   dp_status_type      status;
   logic               csr_sel_max;

   assign pready      = 1'b1;
   assign csr_sel_max = (paddr[CSR_ADDR_W-1:2] == CSR_IDX_MAX_TRIES);
   assign prdata      = csr_sel_max ? CSR_DATA_W'(max_tries_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_tries_ff <= MAX_TRIES_RESET;
      end else if (psel && penable && pwrite && pready && csr_sel_max) begin
         max_tries_ff <= pwdata[TRIES_W-1:0];
      end
   end

   acl_flt_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_func (req_func),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   acl_flt_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .max_tries       (max_tries_ff),
      .req_func        (req_func),
      .req_ip_address  (req_ip_address),
      .req_entry_index (req_entry_index),
      .req_entry_type  (req_entry_type),
      .req_entry_mask  (req_entry_mask),
      .req_entry_range (req_entry_range),
      .rsp_strobe      (rsp_strobe),
      .rsp_verdict     (rsp_verdict),
      .rsp_tries_left  (rsp_tries_left),
      .rsp_table_full  (rsp_table_full)
   );

endmodule
